// ===== rtl/core/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and the hex digit helper of the url decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    localparam int unsigned CFG_W       = 13;
    localparam int unsigned CHAR_W      = 8;
    localparam logic [CFG_W-1:0] BUF_SIZE_RESET = CFG_W'(256);

    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] HEX_LETTER_BASE = 8'd10;

    // result queue sizing: one item may push two results
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = 3;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // hex digits map to 0..15, any other byte stays as it is
    function automatic logic [CHAR_W-1:0] nibble_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h41 + HEX_LETTER_BASE;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + HEX_LETTER_BASE;
        end else begin
            v = c;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/upd_core.sv =====
// ----------------------------------------------------------------------------
// upd_core
// Escape phase, held digit and budget; classifies one byte per valid cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_core
    import upd_pkg::*;
#(
    parameter int unsigned MAX_BUFFER = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    input  wire logic [CHAR_W-1:0] i_in_char,
    input  wire logic              i_in_last,
    output t_push                  o_push
);

    localparam int unsigned BW = (MAX_BUFFER > 1) ? $clog2(MAX_BUFFER) : 1;

    logic [CFG_W-1:0]  r_buffer_size;
    t_phase            r_phase, n_phase;
    logic [CHAR_W-1:0] r_held, n_held;
    logic [BW-1:0]     r_budget, n_budget;
    logic              r_loaded, n_loaded;

    logic [31:0]       w_bs_ext;
    logic [BW-1:0]     w_load;
    logic [BW-1:0]     w_bud;
    logic [CHAR_W-1:0] w_n1, w_n2;
    t_push             w_push;

    // budget taken at the first byte of a string, clamped to the max size
    always_comb begin
        w_bs_ext = 32'(r_buffer_size);
        if (w_bs_ext > 32'(MAX_BUFFER)) begin
            w_load = BW'(MAX_BUFFER - 1);
        end else if (w_bs_ext == 32'd0) begin
            w_load = '0;
        end else begin
            w_load = BW'(w_bs_ext - 32'd1);
        end
        w_bud = r_loaded ? r_budget : w_load;
        w_n1  = nibble_of(r_held);
        w_n2  = nibble_of(i_in_char);
    end

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_budget = r_budget;
        n_loaded = r_loaded;
        w_push   = '0;
        if (i_in_valid) begin
            if (i_in_last) begin
                // a held non-% byte after a cut escape is output alone
                if (r_phase == PH_DIGIT && w_bud != '0) begin
                    if (r_held == CH_PLUS) begin
                        w_push.first = '{ch: CH_SPACE, last: 1'b0};
                        w_push.count = 2'd1;
                    end else if (r_held != CH_PERCENT) begin
                        w_push.first = '{ch: r_held, last: 1'b0};
                        w_push.count = 2'd1;
                    end
                end
                if (r_buffer_size != '0) begin
                    if (w_push.count == 2'd0) begin
                        w_push.first = '{ch: CH_NUL, last: 1'b1};
                        w_push.count = 2'd1;
                    end else begin
                        w_push.second = '{ch: CH_NUL, last: 1'b1};
                        w_push.count  = 2'd2;
                    end
                end
                n_phase  = PH_PLAIN;
                n_held   = '0;
                n_budget = '0;
                n_loaded = 1'b0;
            end else begin
                n_loaded = 1'b1;
                n_budget = w_bud;
                case (r_phase)
                    PH_PCT: begin
                        n_held  = i_in_char;
                        n_phase = PH_DIGIT;
                    end
                    PH_DIGIT: begin
                        w_push.first = '{ch: {w_n1[3:0], 4'b0000} | w_n2, last: 1'b0};
                        w_push.count = 2'd1;
                        n_phase      = PH_PLAIN;
                        n_held       = '0;
                    end
                    default: begin
                        n_phase = PH_PLAIN;
                        if (w_bud != '0) begin
                            n_budget = w_bud - BW'(1);
                            if (i_in_char == CH_PERCENT) begin
                                n_phase = PH_PCT;
                            end else if (i_in_char == CH_PLUS) begin
                                w_push.first = '{ch: CH_SPACE, last: 1'b0};
                                w_push.count = 2'd1;
                            end else begin
                                w_push.first = '{ch: i_in_char, last: 1'b0};
                                w_push.count = 2'd1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUF_SIZE_RESET;
            r_phase       <= PH_PLAIN;
            r_held        <= '0;
            r_budget      <= '0;
            r_loaded      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_buffer_size <= i_cfg_data;
            end
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_budget <= n_budget;
            r_loaded <= n_loaded;
        end
    end

    assign o_push = w_push;

endmodule

`default_nettype wire

// ===== rtl/core/upd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// upd_out_fifo
// Small queue taking up to two results a cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_out_fifo
    import upd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_push             i_push,
    output logic                   o_room,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [CHAR_W-1:0]      o_m_tdata,
    output logic                   o_m_tlast
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic [FIFO_AW-1:0]   w_wr_ptr_nxt;
    logic                 w_pop;

    assign w_pop        = (r_count != '0) && i_m_tready;
    assign w_wr_ptr_nxt = r_wr_ptr + FIFO_AW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push.count);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(w_pop);
        n_count  = r_count + FIFO_CW'(i_push.count) - FIFO_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr_nxt] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // two free slots needed since one request can make two results
    assign o_room     = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = r_mem[r_rd_ptr].ch;
    assign o_m_tlast  = r_mem[r_rd_ptr].last;

endmodule

`default_nettype wire

// ===== rtl/core/url_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder
// Form-style url percent decoder streaming one byte per request.
// ----------------------------------------------------------------------------
// flow: a request is held in the input register and taken by the core
//   once the queue has room; results leave one per cycle on i_m_tready
// throughput: one request per cycle while the queue has room; an end
//   request after a cut escape makes two results; queue depth is four
// reset: synchronous active low; clears escape state, budget and the queue,
//   buffer size returns to 256
`default_nettype none

module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int unsigned MAX_BUFFER = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_data,   // buffer_size
    // input stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,    // [7:0] in_char
    input  wire logic              i_s_tlast,    // end_of_string
    // output stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [7:0]             o_m_tdata,    // [7:0] out_char
    output logic                   o_m_tlast     // out_last
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;
    logic              w_room;
    logic              w_take;
    logic              w_accept;
    t_push             w_push;

    assign w_take      = r_in_valid && w_room;
    assign o_s_tready  = !r_in_valid || w_take;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    upd_core #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (w_take),
        .i_in_char   (r_in_char),
        .i_in_last   (r_in_last),
        .o_push      (w_push)
    );

    upd_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_room     (w_room),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
